[rtl/core/msp_pkg.sv]
// Shared constants and types for the matrix saddle point detector.
// Used by every file of the block; depends on nothing.
package msp_pkg;

    localparam int MAX_SIZE   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int CFG_W      = 7;
    localparam int IDX_W      = $clog2(MAX_SIZE);
    localparam int SIZE_W     = $clog2(MAX_SIZE + 1);
    localparam int MAT_AW     = 2 * IDX_W;

    typedef logic signed [DATA_WIDTH-1:0] data_t;
    typedef logic [IDX_W-1:0]             idx_t;
    typedef logic [SIZE_W-1:0]            size_t;

    // Sequencer to storage controls
    typedef struct packed {
        logic ld_en;     // capture incoming element
        logic rd_en;     // read all three stores at row/col
        logic scan_sel;  // compare operand is the stored element
        logic wr_mat;
        logic wr_row;
        logic wr_col;
        idx_t row;
        idx_t col;
    } store_ctrl_t;

    // Compare unit results back to the sequencer
    typedef struct packed {
        logic row_eq;
        logic row_gt;
        logic col_eq;
        logic col_lt;
    } cmp_res_t;

endpackage

[rtl/core/msp_if.sv]
// Handshake channels of the saddle point detector: element in, result out, size write.
// Depends on msp_pkg.
interface msp_elem_if;
    logic                valid;
    logic                ready;
    msp_pkg::data_t      element_value;
    modport source (output valid, output element_value, input ready);
    modport sink   (input valid, input element_value, output ready);
endinterface

interface msp_result_if;
    logic valid;
    logic ready;
    logic saddle_found;
    modport source (output valid, output saddle_found, input ready);
    modport sink   (input valid, input saddle_found, output ready);
endinterface

interface msp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [msp_pkg::CFG_W-1:0]    matrix_size;
    modport source (output valid, output matrix_size, input ready);
    modport sink   (input valid, input matrix_size, output ready);
endinterface

[rtl/core/msp_cmp_unit.sv]
// Shared signed compare unit: one operand against the row maximum and column minimum.
// Depends on msp_pkg.
module msp_cmp_unit
(
    input  msp_pkg::data_t   operand,
    input  msp_pkg::data_t   row_ref,
    input  msp_pkg::data_t   col_ref,
    output msp_pkg::cmp_res_t res
);

    always_comb
    begin
        res.row_eq = (operand == row_ref);
        res.row_gt = (operand >  row_ref);
        res.col_eq = (operand == col_ref);
        res.col_lt = (operand <  col_ref);
    end

endmodule

[rtl/core/msp_store.sv]
// Matrix store plus row maximum and column minimum memories, with registered reads.
// Depends on msp_pkg.
module msp_store
(
    input  logic                 clk,
    input  msp_pkg::store_ctrl_t ctrl,
    input  msp_pkg::data_t       element_value,
    output msp_pkg::data_t       operand,
    output msp_pkg::data_t       row_rd,
    output msp_pkg::data_t       col_rd
);

    localparam int MAT_DEPTH = msp_pkg::MAX_SIZE * msp_pkg::MAX_SIZE;

    msp_pkg::data_t mat_mem [MAT_DEPTH];
    msp_pkg::data_t row_mem [msp_pkg::MAX_SIZE];
    msp_pkg::data_t col_mem [msp_pkg::MAX_SIZE];

    msp_pkg::data_t elem_reg;
    msp_pkg::data_t mat_rd_reg;
    msp_pkg::data_t row_rd_reg;
    msp_pkg::data_t col_rd_reg;
    logic [msp_pkg::MAT_AW-1:0] addr;

    assign addr = {ctrl.row, ctrl.col};

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_en)
        begin
            elem_reg <= element_value;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_mat)
        begin
            mat_mem[addr] <= elem_reg;
        end
        if (ctrl.rd_en)
        begin
            mat_rd_reg <= mat_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_row)
        begin
            row_mem[ctrl.row] <= elem_reg;
        end
        if (ctrl.rd_en)
        begin
            row_rd_reg <= row_mem[ctrl.row];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_col)
        begin
            col_mem[ctrl.col] <= elem_reg;
        end
        if (ctrl.rd_en)
        begin
            col_rd_reg <= col_mem[ctrl.col];
        end
    end

    assign operand = ctrl.scan_sel ? mat_rd_reg : elem_reg;
    assign row_rd  = row_rd_reg;
    assign col_rd  = col_rd_reg;

endmodule

[rtl/core/msp_seq.sv]
// Sequencer: load phase (transfer then update per element), scan phase, result hand-off.
// Depends on msp_pkg.
module msp_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  msp_pkg::size_t        n_eff,
    input  logic                  cfg_wr,
    input  logic                  in_valid,
    output logic                  in_ready,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  out_found,
    input  msp_pkg::cmp_res_t     cmp,
    output msp_pkg::store_ctrl_t  ctrl
);

    localparam logic [2:0] ST_LOAD  = 3'd0;
    localparam logic [2:0] ST_UPD   = 3'd1;
    localparam logic [2:0] ST_SCAN  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    logic [2:0]    state_reg, state_next;
    msp_pkg::idx_t row_reg, row_next;
    msp_pkg::idx_t col_reg, col_next;
    logic          pvld_reg, pvld_next;
    logic          found_reg, found_next;
    logic          row_last, col_last;

    assign col_last = (msp_pkg::SIZE_W'(col_reg) == n_eff - msp_pkg::SIZE_W'(1));
    assign row_last = (msp_pkg::SIZE_W'(row_reg) == n_eff - msp_pkg::SIZE_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        pvld_next     = 1'b0;
        found_next    = found_reg;
        ctrl          = '0;
        ctrl.row      = row_reg;
        ctrl.col      = col_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;

        // compare the stored element read in the previous scan cycle
        if (pvld_reg && cmp.row_eq && cmp.col_eq)
        begin
            found_next = 1'b1;
        end

        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctrl.ld_en = 1'b1;
                    ctrl.rd_en = 1'b1;
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                ctrl.wr_mat = 1'b1;
                ctrl.wr_row = (col_reg == '0) || cmp.row_gt;
                ctrl.wr_col = (row_reg == '0) || cmp.col_lt;
                state_next  = ST_LOAD;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        row_next   = '0;
                        found_next = 1'b0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        row_next = row_reg + msp_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + msp_pkg::IDX_W'(1);
                end
            end
            ST_SCAN:
            begin
                ctrl.rd_en    = 1'b1;
                ctrl.scan_sel = 1'b1;
                pvld_next     = 1'b1;
                if (col_last)
                begin
                    col_next = '0;
                    if (row_last)
                    begin
                        row_next   = '0;
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        row_next = row_reg + msp_pkg::IDX_W'(1);
                    end
                end
                else
                begin
                    col_next = col_reg + msp_pkg::IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                ctrl.scan_sel = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = ST_LOAD;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // a size write restarts the matrix
        if (cfg_wr)
        begin
            row_next = '0;
            col_next = '0;
        end
    end

    assign out_found = found_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            row_reg   <= '0;
            col_reg   <= '0;
            pvld_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            pvld_reg  <= pvld_next;
            found_reg <= found_next;
        end
    end

endmodule

[rtl/core/matrix_saddle_point_detect.sv]
// Top level of the matrix saddle point detector.
// Depends on msp_pkg, msp_if, msp_cmp_unit, msp_store and msp_seq.
//
// Elements of an n by n signed matrix arrive row-major on the element
// channel, n taken from the size register (0 acts as 1, above 64 acts as 64).
// Each element passes through a transfer cycle that reads the current row
// maximum and column minimum, then an update cycle in which the shared
// comparator decides whether they are replaced and the element is written to
// the matrix store. After the n*n-th element the block is not ready while it
// scans the store, one element per cycle through the same comparator, and
// while it waits for the result transfer.
// The single read port of the matrix store sets the scan length. One result
// transfer follows each matrix: saddle_found is 1 if some element equals both
// its row maximum and its column minimum. A size write restarts the matrix in
// progress; write it only while the block is idle.
module matrix_saddle_point_detect
(
    input  logic              clk,
    input  logic              rst_n,
    msp_cfg_if.sink           cfg,
    msp_elem_if.sink          elem,
    msp_result_if.source      result
);

    logic [msp_pkg::CFG_W-1:0] size_reg;
    msp_pkg::size_t            n_eff;
    logic                      cfg_wr;
    logic                      size_big;

    msp_pkg::store_ctrl_t      ctrl;
    msp_pkg::cmp_res_t         cmp;
    msp_pkg::data_t            operand;
    msp_pkg::data_t            row_rd;
    msp_pkg::data_t            col_rd;

    // Size register: always ready, so a write is one transfer
    assign cfg.ready = 1'b1;
    assign cfg_wr    = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= msp_pkg::CFG_W'(1);
        end
        else if (cfg_wr)
        begin
            size_reg <= cfg.matrix_size;
        end
    end

    // Clamp the size to the supported range
    assign size_big = ({{msp_pkg::SIZE_W{1'b0}}, size_reg} >
                       (msp_pkg::CFG_W + msp_pkg::SIZE_W)'(msp_pkg::MAX_SIZE));

    always_comb
    begin
        if (size_reg == '0)
        begin
            n_eff = msp_pkg::SIZE_W'(1);
        end
        else if (size_big)
        begin
            n_eff = msp_pkg::SIZE_W'(msp_pkg::MAX_SIZE);
        end
        else
        begin
            n_eff = msp_pkg::SIZE_W'(size_reg);
        end
    end

    msp_seq u_seq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_eff     (n_eff),
        .cfg_wr    (cfg_wr),
        .in_valid  (elem.valid),
        .in_ready  (elem.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_found (result.saddle_found),
        .cmp       (cmp),
        .ctrl      (ctrl)
    );

    msp_store u_store
    (
        .clk           (clk),
        .ctrl          (ctrl),
        .element_value (elem.element_value),
        .operand       (operand),
        .row_rd        (row_rd),
        .col_rd        (col_rd)
    );

    // One comparator serves both the running extremes and the scan
    msp_cmp_unit u_cmp
    (
        .operand (operand),
        .row_ref (row_rd),
        .col_ref (col_rd),
        .res     (cmp)
    );

endmodule
